// File: design/btp_pkg.sv
package btp_pkg;

    // field widths fixed by the item format
    localparam int INDEX_W     = 20;
    localparam int BIN_W       = 8;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 10;
    localparam int SPLIT_POS_W = 11;

    // item kinds
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PART  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // result kinds
    typedef enum logic {
        RES_SPLIT = 1'b0,
        RES_READ  = 1'b1
    } res_kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [INDEX_W-1:0]         sample_index;
        logic [BIN_W-1:0]           bin_value;
        logic signed [VALUE_W-1:0]  grad;
        logic signed [VALUE_W-1:0]  hess;
        logic [BIN_W-1:0]           split_bin;
        logic [POS_W-1:0]           position;
    } in_item_t;

    typedef struct packed {
        res_kind_t                  result_kind;
        logic [SPLIT_POS_W-1:0]     split_position;
        logic [INDEX_W-1:0]         out_index;
        logic [BIN_W-1:0]           out_bin;
        logic signed [VALUE_W-1:0]  out_grad;
        logic signed [VALUE_W-1:0]  out_hess;
        logic                       fault;
    } out_item_t;

    // one stored record
    typedef struct packed {
        logic [INDEX_W-1:0]         idx;
        logic [BIN_W-1:0]           bin;
        logic signed [VALUE_W-1:0]  grad;
        logic signed [VALUE_W-1:0]  hess;
    } record_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // input item taken this cycle
        logic rd_ptr;    // read records at both pointers
        logic rd_pos;    // read record at the requested position
        logic lo_inc;    // advance left pointer
        logic hi_dec;    // retreat right pointer
        logic wr_lo;     // first half of a swap: right record into left slot
        logic wr_hi;     // second half of a swap: left record into right slot
        logic load_out;  // load the output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic lo_lt_hi;  // left pointer still at or below right pointer
        logic lo_left;   // record at left pointer belongs to the front
        logic hi_right;  // record at right pointer belongs to the back
        logic out_free;  // output register can take a result
    } stat_t;

endpackage

// File: design/btp_ctrl.sv
module btp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  btp_pkg::kind_t    s_kind,
    output logic              s_ready,
    input  btp_pkg::stat_t    stat,
    output btp_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P_READ,
        ST_P_EVAL,
        ST_P_SWAP_LO,
        ST_P_SWAP_HI,
        ST_R_READ,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // sequencing and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    unique case (s_kind) inside
                        btp_pkg::KIND_PART:                     state_next = ST_P_READ;
                        btp_pkg::KIND_READ:                     state_next = ST_R_READ;
                        btp_pkg::KIND_LOAD, btp_pkg::KIND_CLEAR: state_next = ST_IDLE;
                        default:                                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_P_READ: begin
                cmd.rd_ptr = 1'b1;
                state_next = ST_P_EVAL;
            end
            ST_P_EVAL: begin
                if (!stat.lo_lt_hi) begin
                    state_next = ST_EMIT;
                end else if (stat.lo_left) begin
                    cmd.lo_inc = 1'b1;
                    state_next = ST_P_READ;
                end else if (stat.hi_right) begin
                    cmd.hi_dec = 1'b1;
                    state_next = ST_P_READ;
                end else begin
                    state_next = ST_P_SWAP_LO;
                end
            end
            ST_P_SWAP_LO: begin
                cmd.wr_lo  = 1'b1;
                state_next = ST_P_SWAP_HI;
            end
            ST_P_SWAP_HI: begin
                cmd.wr_hi  = 1'b1;
                state_next = ST_P_READ;
            end
            ST_R_READ: begin
                cmd.rd_pos = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a partition item holds off further input until its walk is done
    a_part_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == btp_pkg::KIND_PART) |=> !s_ready)
        else $error("input taken right after a partition item");

endmodule

// File: design/btp_dpath.sv
module btp_dpath #(
    parameter int ENTRIES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  btp_pkg::cmd_t       cmd,
    input  btp_pkg::in_item_t   s_data,
    output btp_pkg::stat_t      stat,
    input  logic                m_ready,
    output logic                m_valid,
    output btp_pkg::out_item_t  m_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = AW + btp_pkg::POS_W;

    // record memory: one write port, two registered read ports
    btp_pkg::record_t mem [ENTRIES];

    btp_pkg::kind_t                  kind_reg;
    logic [btp_pkg::BIN_W-1:0]       split_reg;
    logic [btp_pkg::POS_W-1:0]       pos_reg;
    logic [CW-1:0]                   count_reg;
    logic                            drop_reg;
    logic [CW-1:0]                   lo_reg;
    logic [CW-1:0]                   hip_reg;     // right pointer plus one
    btp_pkg::record_t                rd_a_reg;
    btp_pkg::record_t                rd_b_reg;
    logic                            m_valid_reg;
    btp_pkg::out_item_t              m_data_reg;
    btp_pkg::out_item_t              m_data_next;

    logic                            full;
    logic [CW-1:0]                   hip_m1;
    logic [AW-1:0]                   hi_addr;
    logic [XW-1:0]                   pos_wide;
    logic [AW-1:0]                   ra_addr;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    btp_pkg::record_t                wr_data;
    logic                            rd_fault;

    assign full     = (count_reg == CW'(ENTRIES));
    assign hip_m1   = hip_reg - 1'b1;
    assign hi_addr  = hip_m1[AW-1:0];
    assign pos_wide = XW'(pos_reg);
    assign ra_addr  = cmd.rd_pos ? pos_wide[AW-1:0] : lo_reg[AW-1:0];

    // write port select: load append or one half of a swap
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = lo_reg[AW-1:0];
        wr_data = rd_b_reg;
        if (cmd.accept && s_data.kind == btp_pkg::KIND_LOAD && !full) begin
            wr_en        = 1'b1;
            wr_addr      = count_reg[AW-1:0];
            wr_data.idx  = s_data.sample_index;
            wr_data.bin  = s_data.bin_value;
            wr_data.grad = s_data.grad;
            wr_data.hess = s_data.hess;
        end else if (cmd.wr_lo) begin
            wr_en = 1'b1;
        end else if (cmd.wr_hi) begin
            wr_en   = 1'b1;
            wr_addr = hi_addr;
            wr_data = rd_a_reg;
        end
    end

    // memory access
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_ptr || cmd.rd_pos) begin
            rd_a_reg <= mem[ra_addr];
        end
        if (cmd.rd_ptr) begin
            rd_b_reg <= mem[hi_addr];
        end
    end

    // item fields kept for the length of the item, and the output register
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg  <= s_data.kind;
            split_reg <= s_data.split_bin;
            pos_reg   <= s_data.position;
        end
        if (cmd.load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    // count, drop flag, pointers and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            lo_reg      <= '0;
            hip_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                unique case (s_data.kind)
                    btp_pkg::KIND_LOAD: begin
                        if (full) begin
                            drop_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    btp_pkg::KIND_PART: begin
                        lo_reg  <= '0;
                        hip_reg <= count_reg;
                    end
                    btp_pkg::KIND_CLEAR: begin
                        count_reg <= '0;
                        drop_reg  <= 1'b0;
                    end
                    btp_pkg::KIND_READ: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.lo_inc) begin
                lo_reg <= lo_reg + 1'b1;
            end
            if (cmd.hi_dec) begin
                hip_reg <= hip_m1;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result formatting
    assign rd_fault = !((32'(pos_reg) < 32'(count_reg)) && (32'(pos_reg) < 32'(ENTRIES)));

    always_comb begin
        m_data_next = '0;
        if (kind_reg == btp_pkg::KIND_PART) begin
            m_data_next.result_kind    = btp_pkg::RES_SPLIT;
            m_data_next.split_position = (btp_pkg::SPLIT_POS_W)'(lo_reg);
            m_data_next.fault          = drop_reg;
        end else begin
            m_data_next.result_kind = btp_pkg::RES_READ;
            m_data_next.fault       = rd_fault;
            if (!rd_fault) begin
                m_data_next.out_index = rd_a_reg.idx;
                m_data_next.out_bin   = rd_a_reg.bin;
                m_data_next.out_grad  = rd_a_reg.grad;
                m_data_next.out_hess  = rd_a_reg.hess;
            end
        end
    end

    // status to the controller
    assign stat.lo_lt_hi = (lo_reg < hip_reg);
    assign stat.lo_left  = (rd_a_reg.bin <= split_reg);
    assign stat.hi_right = (rd_b_reg.bin > split_reg);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // pointers never cross by more than meeting
    a_ptr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= hip_reg)
        else $error("left pointer passed right pointer");

    // swaps only happen on a live pointer pair and always complete
    a_swap_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_lo |-> (lo_reg < hip_reg))
        else $error("swap with crossed pointers");

    a_swap_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_lo |=> cmd.wr_hi)
        else $error("swap left half without right half");

    // a pending result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while stalled");

endmodule

// File: design/bin_threshold_partition.sv
// load and clear items give no result; a read goes through the read and emit states
// a partition of n records makes 0 to n/2 swaps
// the partition rate is set by the two-read, one-write record memory: each pointer step
// passes a read state and a compare state, each swap two write states on the single write port
// one item in flight at a time; input is taken again once the result is in the output register
// reset (aresetn low, synchronous) empties the record count and drop flag; records are not cleared
module bin_threshold_partition #(
    parameter int ENTRIES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  btp_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output btp_pkg::out_item_t  m_data
);

    btp_pkg::cmd_t  cmd;
    btp_pkg::stat_t stat;

    // sequencer
    btp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // record store, pointers and output register
    btp_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// File: tb/bin_threshold_partition_test.sv
`timescale 1ns / 1ps

module bin_threshold_partition_test;

    localparam int DEPTH = 1024;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    btp_pkg::in_item_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    btp_pkg::out_item_t  m_data;

    bin_threshold_partition #(.ENTRIES(DEPTH)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // mirror of the record store
    btp_pkg::record_t    recs [DEPTH];
    int unsigned         rec_count = 0;
    bit                  dropped = 1'b0;

    btp_pkg::in_item_t   queued_cmds [$];
    btp_pkg::out_item_t  due_results [$];
    btp_pkg::out_item_t  want;

    int unsigned planned_count = 0;
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned n_loads = 0, n_parts = 0, n_reads = 0, n_clears = 0, n_drops = 0;

    bit          in_taken = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_left = 0;
    bit          held = 1'b0;
    int unsigned cyc = 0;
    string       diffs;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // idle lengths: mostly short, a few long, none during calm stretches
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((cyc % 1500) < 300) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic btp_pkg::in_item_t rand_item(input btp_pkg::kind_t k);
        btp_pkg::in_item_t it;
        it.kind         = k;
        it.sample_index = (btp_pkg::INDEX_W)'($urandom_range(0, 20'hfffff));
        it.bin_value    = (btp_pkg::BIN_W)'($urandom_range(0, 255));
        it.grad         = $urandom;
        it.hess         = $urandom;
        it.split_bin    = (btp_pkg::BIN_W)'($urandom_range(0, 255));
        it.position     = (btp_pkg::POS_W)'($urandom_range(0, DEPTH - 1));
        return it;
    endfunction

    task automatic queue_item(input btp_pkg::in_item_t it);
        queued_cmds.push_back(it);
        items_queued++;
        if (it.kind == btp_pkg::KIND_LOAD && planned_count < DEPTH)
            planned_count++;
        else if (it.kind == btp_pkg::KIND_CLEAR)
            planned_count = 0;
    endtask

    task automatic queue_load(input logic [btp_pkg::INDEX_W-1:0] idx,
                              input logic [btp_pkg::BIN_W-1:0] bin,
                              input logic [btp_pkg::VALUE_W-1:0] g,
                              input logic [btp_pkg::VALUE_W-1:0] h);
        btp_pkg::in_item_t it;
        it = rand_item(btp_pkg::KIND_LOAD);
        it.sample_index = idx;
        it.bin_value    = bin;
        it.grad         = g;
        it.hess         = h;
        queue_item(it);
    endtask

    task automatic queue_op(input btp_pkg::kind_t k, input int unsigned arg);
        btp_pkg::in_item_t it;
        it = rand_item(k);
        if (k == btp_pkg::KIND_PART)
            it.split_bin = arg[btp_pkg::BIN_W-1:0];
        if (k == btp_pkg::KIND_READ)
            it.position = arg[btp_pkg::POS_W-1:0];
        queue_item(it);
    endtask

    // apply one accepted item to the mirror and queue the result it owes
    task automatic mirror_store(input btp_pkg::in_item_t it);
        btp_pkg::out_item_t r;
        btp_pkg::record_t   t;
        int                 lo, hi;
        r = '0;
        case (it.kind)
            btp_pkg::KIND_LOAD: begin
                n_loads++;
                if (rec_count < DEPTH) begin
                    recs[rec_count] = {it.sample_index, it.bin_value, it.grad, it.hess};
                    rec_count++;
                end else begin
                    dropped = 1'b1;
                    n_drops++;
                end
            end
            btp_pkg::KIND_PART: begin
                n_parts++;
                lo = 0;
                hi = int'(rec_count) - 1;
                // two pointers meet in the middle, swapping misplaced pairs
                while (lo <= hi) begin
                    while (lo <= hi && recs[lo].bin <= it.split_bin)
                        lo++;
                    while (lo <= hi && recs[hi].bin > it.split_bin)
                        hi--;
                    if (lo <= hi) begin
                        t       = recs[lo];
                        recs[lo] = recs[hi];
                        recs[hi] = t;
                    end
                end
                r.result_kind    = btp_pkg::RES_SPLIT;
                r.split_position = lo[btp_pkg::SPLIT_POS_W-1:0];
                r.fault          = dropped;
                due_results.push_back(r);
            end
            btp_pkg::KIND_READ: begin
                n_reads++;
                r.result_kind = btp_pkg::RES_READ;
                if (it.position < rec_count) begin
                    r.out_index = recs[it.position].idx;
                    r.out_bin   = recs[it.position].bin;
                    r.out_grad  = recs[it.position].grad;
                    r.out_hess  = recs[it.position].hess;
                end else begin
                    r.fault = 1'b1;
                end
                due_results.push_back(r);
            end
            default: begin
                n_clears++;
                rec_count = 0;
                dropped   = 1'b0;
            end
        endcase
    endtask

    task automatic report(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // sample both handshakes at the rising edge
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            items_taken++;
            mirror_store(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report($sformatf("result %0d arrived with none outstanding", results_seen));
            end else begin
                want  = due_results.pop_front();
                diffs = "";
                if (m_data.result_kind !== want.result_kind)
                    diffs = {diffs, $sformatf(" kind %0d/%0d", m_data.result_kind,
                                              want.result_kind)};
                if (m_data.split_position !== want.split_position)
                    diffs = {diffs, $sformatf(" split %0d/%0d", m_data.split_position,
                                              want.split_position)};
                if (m_data.out_index !== want.out_index)
                    diffs = {diffs, $sformatf(" index %h/%h", m_data.out_index,
                                              want.out_index)};
                if (m_data.out_bin !== want.out_bin)
                    diffs = {diffs, $sformatf(" bin %h/%h", m_data.out_bin, want.out_bin)};
                if (m_data.out_grad !== want.out_grad)
                    diffs = {diffs, $sformatf(" grad %h/%h", m_data.out_grad, want.out_grad)};
                if (m_data.out_hess !== want.out_hess)
                    diffs = {diffs, $sformatf(" hess %h/%h", m_data.out_hess, want.out_hess)};
                if (m_data.fault !== want.fault)
                    diffs = {diffs, $sformatf(" fault %b/%b", m_data.fault, want.fault)};
                if (diffs != "")
                    report($sformatf("result %0d (got/expected):%s", results_seen, diffs));
            end
        end
    end

    // input driver: next item once the current one is taken, after a random gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_valid <= 1'b0;
            end else if (queued_cmds.size() > 0) begin
                s_data  <= queued_cmds.pop_front();
                s_valid <= 1'b1;
                in_gap  <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!held && results_seen >= 40) begin
            held      <= 1'b1;
            hold_left <= 500;
            m_ready   <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                out_gap <= pick_gap();
        end
    end

    initial begin
        #15000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n, base, spread, b, i;

        // directed: empty block, field extremes, all-front and all-back splits
        queue_op(btp_pkg::KIND_PART, 0);
        queue_op(btp_pkg::KIND_READ, 0);
        queue_load(20'h00000, 8'h00, 32'h8000_0000, 32'h7fff_ffff);
        queue_load(20'hfffff, 8'hff, 32'h7fff_ffff, 32'h8000_0000);
        queue_load(20'h55555, 8'h80, 32'h0000_0000, 32'hffff_ffff);
        queue_load(20'haaaaa, 8'h7f, 32'h0000_0001, 32'h0001_0000);
        queue_load(20'h12345, 8'h01, 32'hffff_0000, 32'h0000_8000);
        queue_op(btp_pkg::KIND_PART, 8'h7f);
        for (i = 0; i < 5; i++)
            queue_op(btp_pkg::KIND_READ, i);
        queue_op(btp_pkg::KIND_READ, 5);
        queue_op(btp_pkg::KIND_READ, DEPTH - 1);
        queue_op(btp_pkg::KIND_PART, 8'hff);
        queue_op(btp_pkg::KIND_CLEAR, 0);
        queue_load(20'h0f0f0, 8'hc0, 32'h0002_8000, 32'hfffe_0000);
        queue_load(20'hf0f0f, 8'hff, 32'hffff_ffff, 32'h0000_0001);
        queue_op(btp_pkg::KIND_PART, 0);
        queue_op(btp_pkg::KIND_READ, 1);
        queue_op(btp_pkg::KIND_CLEAR, 0);
        queue_op(btp_pkg::KIND_READ, 0);
        queue_op(btp_pkg::KIND_PART, 0);

        // random sets: mostly small, a few larger; splits near the loaded bins
        while (items_queued < 580) begin
            if ($urandom_range(0, 3) == 0 || planned_count > 300)
                queue_op(btp_pkg::KIND_CLEAR, 0);
            n      = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 16)
                                                 : $urandom_range(30, 120);
            base   = $urandom_range(0, 255);
            spread = $urandom_range(0, 40);
            repeat (n) begin
                b = base + int'($urandom_range(0, 2 * spread)) - spread;
                b = (b < 0) ? 0 : (b > 255) ? 255 : b;
                queue_load((btp_pkg::INDEX_W)'($urandom_range(0, 20'hfffff)),
                           (btp_pkg::BIN_W)'(b), $urandom, $urandom);
            end
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0: queue_op(btp_pkg::KIND_PART, 0);
                    1: queue_op(btp_pkg::KIND_PART, 255);
                    default: begin
                        b = base + int'($urandom_range(0, 2 * spread)) - spread;
                        queue_op(btp_pkg::KIND_PART, (b < 0) ? 0 : (b > 255) ? 255 : b);
                    end
                endcase
                repeat ($urandom_range(0, 4)) begin
                    if (planned_count > 0 && $urandom_range(0, 4) != 0)
                        queue_op(btp_pkg::KIND_READ, $urandom_range(0, planned_count - 1));
                    else if ($urandom_range(0, 1) == 0)
                        queue_op(btp_pkg::KIND_READ, planned_count);
                    else
                        queue_op(btp_pkg::KIND_READ, $urandom_range(0, DEPTH - 1));
                end
            end
            // noise: any kind, any fields
            repeat ($urandom_range(0, 2))
                queue_item(rand_item(btp_pkg::kind_t'($urandom_range(0, 3))));
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // drain
        while (items_taken < items_queued)
            @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("covered %0d items: %0d loads (%0d dropped at capacity), %0d partitions,",
                 items_taken, n_loads, n_drops, n_parts);
        $display("  %0d reads, %0d clears; %0d results compared, %0d mismatches",
                 n_reads, n_clears, results_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
